// ----- rtl/core/tha_pkg.sv -----
// types and constants shared by the type hierarchy ancestor table
`timescale 1ns / 1ps

package tha_pkg;

  localparam int CODE_W     = 8;
  localparam int CODE_LIMIT = 256;
  localparam int CMP_W      = 9;

  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_QUERY    = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2,
    STATUS_LOOP    = 2'd3
  } status_t;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] parent_id;
    logic [CODE_W-1:0] subject_code;
    logic [CODE_W-1:0] target_code;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] assigned_code;
    logic              is_ancestor;
    status_t           status;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

endpackage

// ----- rtl/core/tha_parent_mem.sv -----
// parent code memory, one write port and one registered read port
`timescale 1ns / 1ps

module tha_parent_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [tha_pkg::CODE_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [tha_pkg::CODE_W-1:0]  rd_data
);

  logic [tha_pkg::CODE_W-1:0] mem [DEPTH];
  logic [tha_pkg::CODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tha_ctrl.sv -----
// sequencer: registration, parent walk and output register
`timescale 1ns / 1ps

module tha_ctrl #(
  parameter int TABLE_DEPTH = 256,
  parameter int IDX_W       = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tha_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tha_pkg::out_item_t                  out_data,
  output logic                                mem_wr_en,
  output logic [IDX_W-1:0]                    mem_wr_addr,
  output logic [tha_pkg::CODE_W-1:0]          mem_wr_data,
  output logic [IDX_W-1:0]                    mem_rd_addr,
  input  logic [tha_pkg::CODE_W-1:0]          mem_rd_data
);

  localparam int CAPACITY = (TABLE_DEPTH < tha_pkg::CODE_LIMIT) ? TABLE_DEPTH
                                                                : tha_pkg::CODE_LIMIT;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(CAPACITY + 2);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(CAPACITY);
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(CAPACITY + 1);

  tha_pkg::state_t            state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [STEP_W-1:0]          steps_r, steps_nxt;
  logic                       first_r, first_nxt;
  logic [tha_pkg::CODE_W-1:0] subject_r, subject_nxt;
  logic [tha_pkg::CODE_W-1:0] target_r, target_nxt;
  logic [tha_pkg::CODE_W-1:0] prev_r, prev_nxt;
  logic                       out_valid_r, out_valid_nxt;
  tha_pkg::out_item_t         out_data_r, out_data_nxt;

  logic                       accept;
  logic                       slot_free;
  logic                       table_full;
  logic [tha_pkg::CODE_W-1:0] cur;
  logic                       cur_invalid;
  logic                       walk_done;
  tha_pkg::out_item_t         walk_res;

  assign slot_free  = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == tha_pkg::ST_IDLE) && slot_free);
  assign accept     = in_valid && !in_stall;
  assign table_full = (count_r >= CNT_FULL);

  assign cur         = first_r ? subject_r : mem_rd_data;
  assign cur_invalid = ({1'b0, cur} >= tha_pkg::CMP_W'(count_r));
  assign mem_rd_addr = cur[IDX_W-1:0];

  assign mem_wr_en   = accept && (in_data.mode == tha_pkg::MODE_REGISTER) && !table_full;
  assign mem_wr_addr = count_r[IDX_W-1:0];
  assign mem_wr_data = in_data.parent_id;

  // one level of the walk per cycle
  always_comb begin
    walk_done              = 1'b1;
    walk_res.assigned_code = '0;
    walk_res.is_ancestor   = 1'b0;
    walk_res.status        = tha_pkg::STATUS_OK;
    if (steps_r == STEP_LIMIT) begin
      walk_res.status = tha_pkg::STATUS_LOOP;
    end else if (cur_invalid) begin
      walk_res.status = tha_pkg::STATUS_INVALID;
    end else if (cur == target_r) begin
      walk_res.is_ancestor = 1'b1;
    end else if (cur == prev_r) begin
      walk_res.status = tha_pkg::STATUS_OK;
    end else begin
      walk_done = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    first_nxt     = first_r;
    subject_nxt   = subject_r;
    target_nxt    = target_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      tha_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == tha_pkg::MODE_REGISTER) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.is_ancestor = 1'b0;
            if (table_full) begin
              out_data_nxt.assigned_code = '0;
              out_data_nxt.status        = tha_pkg::STATUS_FULL;
            end else begin
              out_data_nxt.assigned_code = tha_pkg::CODE_W'(count_r);
              out_data_nxt.status        = tha_pkg::STATUS_OK;
              count_nxt                  = count_r + CNT_W'(1);
            end
          end else begin
            subject_nxt = in_data.subject_code;
            target_nxt  = in_data.target_code;
            prev_nxt    = '0;
            steps_nxt   = '0;
            first_nxt   = 1'b1;
            state_nxt   = tha_pkg::ST_WALK;
          end
        end
      end
      tha_pkg::ST_WALK: begin
        if (walk_done) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = walk_res;
          state_nxt     = tha_pkg::ST_IDLE;
        end else begin
          prev_nxt  = cur;
          steps_nxt = steps_r + STEP_W'(1);
          first_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = tha_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tha_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r    <= steps_nxt;
    first_r    <= first_nxt;
    subject_r  <= subject_nxt;
    target_r   <= target_nxt;
    prev_r     <= prev_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above capacity");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tha_pkg::ST_WALK) |-> (steps_r <= STEP_LIMIT))
    else $error("walk step counter past limit");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> ((state_r == tha_pkg::ST_IDLE) && !table_full))
    else $error("memory write outside idle or into full table");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tha_pkg::ST_WALK) && walk_done) |=>
      (out_valid_r && (state_r == tha_pkg::ST_IDLE)))
    else $error("finished walk gave no result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tha_pkg::ST_WALK) && walk_done) |-> slot_free)
    else $error("walk finished while output slot held");

endmodule

// ----- rtl/core/type_hierarchy_ancestor_table.sv -----
// top level of the type hierarchy ancestor table: a register item appends a parent code at
// the next free code, returned as assigned_code (status full once min(TABLE_DEPTH, 256)
// types exist); a query item walks from subject_code up the parent chain with one memory
// read per level, set by the single read port of the parent memory, and ends with status
// loop when the walk limit is hit; the next item is taken once the result has moved into
// the output register and the output is not stalled, and the parent memory needs no
// clearing after reset since only filled entries are ever used
`timescale 1ns / 1ps

module type_hierarchy_ancestor_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tha_pkg::out_item_t out_data
);

  localparam int CAPACITY = (TABLE_DEPTH < tha_pkg::CODE_LIMIT) ? TABLE_DEPTH
                                                                : tha_pkg::CODE_LIMIT;
  localparam int IDX_W = $clog2(CAPACITY);

  logic                       mem_wr_en;
  logic [IDX_W-1:0]           mem_wr_addr;
  logic [tha_pkg::CODE_W-1:0] mem_wr_data;
  logic [IDX_W-1:0]           mem_rd_addr;
  logic [tha_pkg::CODE_W-1:0] mem_rd_data;

  tha_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tha_parent_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- tb/type_hierarchy_ancestor_table_tb.sv -----
// self-checking testbench for the type hierarchy ancestor table
`timescale 1ns / 1ps

module type_hierarchy_ancestor_table_tb;

  localparam int TABLE_DEPTH = 256;
  localparam int CAPACITY = (TABLE_DEPTH < tha_pkg::CODE_LIMIT) ? TABLE_DEPTH
                                                                : tha_pkg::CODE_LIMIT;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tha_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tha_pkg::out_item_t out_data;

  // shadow copy of the parent table
  logic [tha_pkg::CODE_W-1:0] parent_model [CAPACITY];
  logic [tha_pkg::CMP_W-1:0] filled_count = '0;

  tha_pkg::out_item_t pending_answers [$];
  tha_pkg::out_item_t expected_answer;
  int mismatch_count = 0;
  bit steady_flow = 1'b0;

  type_hierarchy_ancestor_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < 32);
  end

  // answer of one item, updating the shadow table
  function automatic tha_pkg::out_item_t table_answer(input tha_pkg::in_item_t item);
    tha_pkg::out_item_t res;
    logic [tha_pkg::CMP_W-1:0] cur;
    logic [tha_pkg::CMP_W-1:0] prev;
    bit done;
    res = '0;
    res.status = tha_pkg::STATUS_OK;
    if (item.mode == tha_pkg::MODE_REGISTER) begin
      if (filled_count >= CAPACITY) begin
        res.status = tha_pkg::STATUS_FULL;
      end else begin
        parent_model[filled_count] = item.parent_id;
        res.assigned_code = filled_count[tha_pkg::CODE_W-1:0];
        filled_count = filled_count + tha_pkg::CMP_W'(1);
      end
    end else begin
      cur = {1'b0, item.subject_code};
      prev = '0;
      done = 1'b0;
      res.status = tha_pkg::STATUS_LOOP;
      for (int step = 0; step <= CAPACITY && !done; step++) begin
        if (cur >= filled_count) begin
          res.status = tha_pkg::STATUS_INVALID;
          done = 1'b1;
        end else if (cur[tha_pkg::CODE_W-1:0] == item.target_code) begin
          res.status = tha_pkg::STATUS_OK;
          res.is_ancestor = 1'b1;
          done = 1'b1;
        end else if (cur == prev) begin
          res.status = tha_pkg::STATUS_OK;
          done = 1'b1;
        end else begin
          prev = cur;
          cur = {1'b0, parent_model[cur[tha_pkg::CODE_W-1:0]]};
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: code %0d hit %0b status %0d",
                   out_data.assigned_code, out_data.is_ancestor, out_data.status);
      end else begin
        expected_answer = pending_answers.pop_front();
        if (out_data.assigned_code !== expected_answer.assigned_code ||
            out_data.is_ancestor !== expected_answer.is_ancestor ||
            out_data.status !== expected_answer.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected code %0d hit %0b status %0d, ",
                      "got code %0d hit %0b status %0d"},
                     expected_answer.assigned_code, expected_answer.is_ancestor,
                     expected_answer.status, out_data.assigned_code,
                     out_data.is_ancestor, out_data.status);
        end
      end
    end
  end

  task automatic send_item(input tha_pkg::in_item_t item);
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers.push_back(table_answer(item));
  endtask

  task automatic register_type(input int parent);
    tha_pkg::in_item_t item;
    item.mode = tha_pkg::MODE_REGISTER;
    item.parent_id = tha_pkg::CODE_W'(parent);
    item.subject_code = tha_pkg::CODE_W'($urandom_range(255));
    item.target_code = tha_pkg::CODE_W'($urandom_range(255));
    send_item(item);
  endtask

  task automatic ask_query(input int subject, input int target);
    tha_pkg::in_item_t item;
    item.mode = tha_pkg::MODE_QUERY;
    item.parent_id = tha_pkg::CODE_W'($urandom_range(255));
    item.subject_code = tha_pkg::CODE_W'(subject);
    item.target_code = tha_pkg::CODE_W'(target);
    send_item(item);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // mostly tree edges, some new roots, forward references and wild codes
  function automatic int pick_parent();
    int roll;
    int free_code;
    roll = $urandom_range(99);
    free_code = (filled_count < CAPACITY) ? int'(filled_count) : 0;
    if (roll < 12 || filled_count == 0) return free_code;
    if (roll < 27) return $urandom_range(255);
    if (roll < 40) return (free_code + $urandom_range(4, 1)) % tha_pkg::CODE_LIMIT;
    return $urandom_range(int'(filled_count) - 1);
  endfunction

  task automatic random_query();
    int subject;
    int target;
    int hops;
    int roll;
    roll = $urandom_range(99);
    if (filled_count > 0 && roll < 80) subject = $urandom_range(int'(filled_count) - 1);
    else subject = $urandom_range(255);
    roll = $urandom_range(99);
    if (roll < 50) begin
      // target taken from the subject's own ancestry
      target = subject;
      hops = $urandom_range(6);
      for (int h = 0; h < hops && target < filled_count; h++) target = parent_model[target];
    end else if (roll < 75 && filled_count > 0) begin
      target = $urandom_range(int'(filled_count) - 1);
    end else begin
      target = $urandom_range(255);
    end
    ask_query(subject, target);
  endtask

  task automatic test_empty_table();
    ask_query(0, 0);
    ask_query(255, 255);
  endtask

  task automatic test_directed_hierarchy();
    register_type(0);
    register_type(0);
    register_type(1);
    register_type(3);
    register_type(200);
    register_type(6);
    register_type(5);
    register_type(255);
    // subject 0 as root, matches and roots
    ask_query(0, 0);
    ask_query(0, 5);
    ask_query(2, 0);
    ask_query(2, 3);
    ask_query(3, 3);
    ask_query(3, 2);
    // unfilled parent, unfilled subject, cycle without a root
    ask_query(4, 0);
    ask_query(255, 0);
    ask_query(7, 255);
    ask_query(5, 0);
    wait_drained();
  endtask

  task automatic test_random_mix(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 40) register_type(pick_parent());
      else random_query();
    end
  endtask

  task automatic test_steady_stretch(input int count);
    wait_drained();
    steady_flow = 1'b1;
    test_random_mix(count);
    steady_flow = 1'b0;
    wait_drained();
  endtask

  task automatic test_table_full();
    while (filled_count < CAPACITY) register_type(pick_parent());
    for (int n = 0; n < 3; n++) register_type($urandom_range(255));
    ask_query(255, 255);
    ask_query(255, 0);
    for (int n = 0; n < 6; n++) random_query();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_directed_hierarchy();
    test_random_mix(300);
    test_steady_stretch(150);
    test_random_mix(250);
    test_table_full();
    wait_drained();
    repeat (CAPACITY + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("type_hierarchy_ancestor_table regression: pass");
    end else begin
      $display("type_hierarchy_ancestor_table regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("type_hierarchy_ancestor_table regression: fail");
    $finish;
  end

endmodule

// ----- type_hierarchy_ancestor_table.f -----
rtl/core/tha_pkg.sv
rtl/core/tha_parent_mem.sv
rtl/core/tha_ctrl.sv
rtl/core/type_hierarchy_ancestor_table.sv
tb/type_hierarchy_ancestor_table_tb.sv
